### design/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the tap tempo footswitch block.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  // Input beat: switch event, millisecond tick and tap timestamp
  typedef struct packed {
    logic [1:0]  switch_event;
    logic [31:0] now_ms;
    logic [31:0] tap_time_us;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  trigger;
    logic [31:0] tap_average_us;
    logic [2:0]  switch_phase;
  } out_item_t;

  // Configuration registers
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 1'b1;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST = 16'd10;
  localparam logic [CFG_DATA_W-1:0] HOLD_RST     = 16'd1000;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [CFG_DATA_W-1:0] hold_ms;
  } cfg_t;

  // Switch event codes
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  // Trigger codes
  localparam logic [1:0] TRIG_NONE    = 2'd0;
  localparam logic [1:0] TRIG_TAP     = 2'd1;
  localparam logic [1:0] TRIG_RESTART = 2'd2;

  // Work handed from the front to the back end
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_LOG     = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [1:0]  trigger;
    logic [2:0]  switch_phase;
    logic [31:0] tap_time_us;
  } cmd_t;

endpackage

`default_nettype wire

### design/tts_front.sv
// ----------------------------------------------------------------------------
// tts_front
// Debounce and hold state machine. Classifies every beat into a back end
// command (nothing, log an interval, restart the log).
// ----------------------------------------------------------------------------
`default_nettype none

module tts_front import tts_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire in_item_t item_i,
  input  wire logic     fire_i,
  output cmd_t          cmd_o
);

  typedef enum logic [5:0] {
    PH_UP          = 6'b000001,
    PH_UP_HELD     = 6'b000010,
    PH_DEB_PRESS   = 6'b000100,
    PH_DOWN        = 6'b001000,
    PH_DEB_RELEASE = 6'b010000,
    PH_DOWN_HELD   = 6'b100000
  } phase_e;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    unique case (ph)
      PH_UP:          code = 3'd0;
      PH_UP_HELD:     code = 3'd1;
      PH_DEB_PRESS:   code = 3'd2;
      PH_DOWN:        code = 3'd3;
      PH_DEB_RELEASE: code = 3'd4;
      PH_DOWN_HELD:   code = 3'd5;
      default:        code = 3'd0;
    endcase
    return code;
  endfunction

  phase_e      phase_q, phase_d;
  logic [31:0] last_q, last_d;
  logic [31:0] since;
  logic        deb_hit, hold_hit, press, release_ev;
  cmd_e        cmd;
  logic [1:0]  trig;

  // Next phase; in the debounce phases and PH_DOWN a later check wins
  always_comb begin
    since      = item_i.now_ms - last_q;
    deb_hit    = since >= {16'd0, cfg_i.debounce_ms};
    hold_hit   = since >= {16'd0, cfg_i.hold_ms};
    press      = item_i.switch_event == EV_PRESS;
    release_ev = item_i.switch_event == EV_RELEASE;
    phase_d    = phase_q;
    last_d     = last_q;
    cmd        = CMD_NONE;
    trig       = TRIG_NONE;
    unique case (phase_q)
      PH_UP: begin
        if (press) begin
          phase_d = PH_DEB_PRESS;
          last_d  = item_i.now_ms;
          cmd     = CMD_LOG;
          trig    = TRIG_TAP;
        end else if (hold_hit) begin
          phase_d = PH_UP_HELD;
        end
      end
      PH_UP_HELD: begin
        if (press) begin
          phase_d = PH_DEB_PRESS;
          last_d  = item_i.now_ms;
          cmd     = CMD_RESTART;
          trig    = TRIG_RESTART;
        end
      end
      PH_DEB_PRESS: begin
        if (release_ev) begin
          phase_d = PH_DEB_RELEASE;
          last_d  = item_i.now_ms;
        end
        if (deb_hit) phase_d = PH_DOWN;
      end
      PH_DOWN: begin
        if (release_ev) begin
          phase_d = PH_DEB_RELEASE;
          last_d  = item_i.now_ms;
        end
        if (hold_hit) phase_d = PH_DOWN_HELD;
      end
      PH_DEB_RELEASE: begin
        if (press) begin
          phase_d = PH_DEB_PRESS;
          last_d  = item_i.now_ms;
        end
        if (deb_hit) phase_d = PH_UP;
      end
      PH_DOWN_HELD: begin
        if (release_ev) begin
          phase_d = PH_DEB_RELEASE;
          last_d  = item_i.now_ms;
        end
      end
      default: phase_d = PH_UP;
    endcase
  end

  // State update on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_UP;
      last_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      last_q  <= last_d;
    end
  end

  assign cmd_o = '{cmd:          cmd,
                   trigger:      trig,
                   switch_phase: phase_code(phase_d),
                   tap_time_us:  item_i.tap_time_us};

endmodule

`default_nettype wire

### design/tts_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tts_cmd_fifo
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_cmd_fifo import tts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output logic      empty_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop)      count_q <= count_q + 2'd1;
      else if (do_pop && !do_push) count_q <= count_q - 2'd1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

### design/tts_back.sv
// ----------------------------------------------------------------------------
// tts_back
// Tap interval log: ring memory, sequential sum of the valid entries, bit
// serial divide by the entry count, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_back import tts_pkg::*; #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire logic cmd_empty_i,
  output logic      cmd_pop_o,
  output out_item_t out_item_o,
  output logic      out_valid_o,
  input  wire logic out_pop_i
);

  localparam int unsigned SLOT_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W  = 32 + SLOT_W;
  localparam int unsigned DCNT_W = $clog2(SUM_W + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [31:0]        ring_q [RING_DEPTH];
  logic [31:0]        rdata_q;
  logic               rd_en, rd_vld_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [CNT_W-1:0]   vcnt_q, n_q, idx_q;
  logic [31:0]        prev_tap_q, mean_q;
  logic [SUM_W-1:0]   acc_q, quo_q;
  logic [CNT_W-1:0]   rem_q;
  logic [DCNT_W-1:0]  dcnt_q;
  logic [1:0]         trig_q;
  logic [2:0]         phase_q;
  logic               out_vld_q;
  out_item_t          out_q;
  logic               out_free, ring_we;
  logic [CNT_W:0]     rem_sh, rem_sub;
  logic               sum_done;

  assign cmd_pop_o   = (state_q == S_IDLE) && !cmd_empty_i;
  assign ring_we     = cmd_pop_o && (cmd_i.cmd == CMD_LOG);
  assign rd_en       = (state_q == S_SUM) && (idx_q != n_q);
  assign sum_done    = (state_q == S_SUM) && (idx_q == n_q) && !rd_vld_q;
  assign out_free    = !out_vld_q || out_pop_i;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // One divide step: bring the next dividend bit into the remainder
  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, n_q};

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.cmd)
            CMD_LOG: state_d = S_SUM;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_SUM:   if (sum_done) state_d = S_DIV;
      S_DIV:   if (dcnt_q == DCNT_W'(1)) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Log state, sum and divide datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      slot_q     <= '0;
      vcnt_q     <= CNT_W'(1);
      prev_tap_q <= '0;
      mean_q     <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (cmd_pop_o) begin
        unique case (cmd_i.cmd)
          CMD_LOG: begin
            prev_tap_q <= cmd_i.tap_time_us;
            slot_q     <= (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
            if (vcnt_q != CNT_W'(RING_DEPTH)) vcnt_q <= vcnt_q + CNT_W'(1);
          end
          CMD_RESTART: begin
            prev_tap_q <= cmd_i.tap_time_us;
            slot_q     <= '0;
            vcnt_q     <= CNT_W'(1);
            mean_q     <= '0;
          end
          default: ;
        endcase
      end
      if ((state_q == S_DIV) && (dcnt_q == DCNT_W'(1))) begin
        mean_q <= (rem_sh >= {1'b0, n_q}) ? {quo_q[30:0], 1'b1} : {quo_q[30:0], 1'b0};
      end
    end
  end

  // Working registers of the sum and the divide
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      trig_q  <= cmd_i.trigger;
      phase_q <= cmd_i.switch_phase;
      n_q     <= vcnt_q;
      idx_q   <= '0;
      acc_q   <= '0;
    end
    if (rd_en) idx_q <= idx_q + CNT_W'(1);
    if ((state_q == S_SUM) && rd_vld_q) acc_q <= acc_q + SUM_W'(rdata_q);
    if (sum_done) begin
      quo_q  <= acc_q;
      rem_q  <= '0;
      dcnt_q <= DCNT_W'(SUM_W);
    end else if (state_q == S_DIV) begin
      dcnt_q <= dcnt_q - DCNT_W'(1);
      if (rem_sh >= {1'b0, n_q}) begin
        rem_q <= rem_sub[CNT_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[CNT_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b0};
      end
    end
  end

  // Interval ring: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_q[slot_q] <= cmd_i.tap_time_us - prev_tap_q;
    if (rd_en)   rdata_q <= ring_q[idx_q[SLOT_W-1:0]];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_vld_q <= 1'b1;
    end else if (out_pop_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && out_free) begin
      out_q <= '{trigger: trig_q, tap_average_us: mean_q, switch_phase: phase_q};
    end
  end

endmodule

`default_nettype wire

### design/tap_tempo_switch.sv
// ----------------------------------------------------------------------------
// tap_tempo_switch
// Footswitch debounce and hold machine with a tap interval averager.
// ----------------------------------------------------------------------------
// Every beat pushed in gives exactly one result beat, in order. The switch
// machine classifies a beat in the cycle it is taken, and a two-entry command
// queue lets the front keep taking beats while the back end works. A press
// from the up phase logs an interval, sums the n valid ring entries (at most
// RING_DEPTH, read one a cycle from the ring) and divides the sum by n in
// SUM_W = 32 + clog2(RING_DEPTH) steps of the bit-serial divider. Any other
// beat goes straight to the result register.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module tap_tempo_switch import tts_pkg::*; #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  push,
  output logic                       full,
  input  wire in_item_t              in_item_i,
  output logic                       empty,
  input  wire logic                  pop,
  output out_item_t                  out_item_o
);

  cfg_t  cfg_q;
  cmd_t  front_cmd, back_cmd;
  logic  in_fire, cmd_empty, cmd_pop, out_valid;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= DEBOUNCE_RST;
      cfg_q.hold_ms     <= HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE: cfg_q.debounce_ms <= cfg_wdata_i;
        REG_HOLD:     cfg_q.hold_ms     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_fire = push && !full;
  assign empty   = !out_valid;

  tts_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .item_i (in_item_i),
    .fire_i (in_fire),
    .cmd_o  (front_cmd)
  );

  tts_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  tts_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid),
    .out_pop_i   (pop)
  );

endmodule

`default_nettype wire
